// ===== hdl/bmnt_pkg.sv =====
// shared types and constants for the box mean threshold unit
package bmnt_pkg;

	// field and register widths
	localparam int PixW = 8;
	localparam int CfgW = 11;
	localparam int ThrW = 9;
	localparam int DimW = 13;
	localparam int HgtW = 11;
	localparam int RowW = 10;
	localparam int SumW = 12;

	// frame limits
	localparam int MinDim    = 3;
	localparam int MaxHeight = 1024;

	// register reset values
	localparam logic [CfgW-1:0] WidthReset  = 11'd640;
	localparam logic [CfgW-1:0] HeightReset = 11'd480;
	localparam logic [ThrW-1:0] ThrReset    = 9'd128;

	// binary result levels
	localparam logic [PixW-1:0] PixBlack = 8'd0;
	localparam logic [PixW-1:0] PixWhite = 8'd255;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_WIDTH     = 2'd0,
		CFG_HEIGHT    = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_index_t;

	// effective frame settings seen by the datapath
	typedef struct packed {
		logic [DimW-1:0] width;
		logic [HgtW-1:0] height;
		logic [SumW-1:0] limit;
	} cfg_t;

endpackage

// ===== hdl/bmnt_ram.sv =====
// generic single write, single read ram with registered read data
module bmnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/bmnt_cfg.sv =====
// configuration registers, dimension clamping and threshold limit
module bmnt_cfg #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic [1:0]                 cfg_index,
	input  logic [bmnt_pkg::CfgW-1:0]  cfg_data,
	output bmnt_pkg::cfg_t             cfg
);

	logic [bmnt_pkg::CfgW-1:0] width_q;
	logic [bmnt_pkg::CfgW-1:0] height_q;
	logic [bmnt_pkg::SumW-1:0] limit_q;

	// result is black when the window sum reaches 9 * (256 - threshold)
	function automatic logic [bmnt_pkg::SumW-1:0] sum_limit(
		input logic [bmnt_pkg::ThrW-1:0] thr
	);
		logic [bmnt_pkg::SumW-1:0] d;
		d = {3'b000, 9'(9'd256 - thr)};
		if (thr[bmnt_pkg::ThrW-1]) begin
			return '0;
		end
		return (d << 3) + d;
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmnt_pkg::WidthReset;
			height_q <= bmnt_pkg::HeightReset;
			limit_q  <= sum_limit(bmnt_pkg::ThrReset);
		end else if (cfg_valid) begin
			case (bmnt_pkg::cfg_index_t'(cfg_index))
				bmnt_pkg::CFG_WIDTH: begin
					width_q <= cfg_data;
				end
				bmnt_pkg::CFG_HEIGHT: begin
					height_q <= cfg_data;
				end
				bmnt_pkg::CFG_THRESHOLD: begin
					limit_q <= sum_limit(cfg_data[bmnt_pkg::ThrW-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// clamp dimensions to the supported range
	always_comb begin
		if (width_q < bmnt_pkg::CfgW'(bmnt_pkg::MinDim)) begin
			cfg.width = bmnt_pkg::DimW'(bmnt_pkg::MinDim);
		end else if (bmnt_pkg::DimW'(width_q) > bmnt_pkg::DimW'(MAX_WIDTH)) begin
			cfg.width = bmnt_pkg::DimW'(MAX_WIDTH);
		end else begin
			cfg.width = bmnt_pkg::DimW'(width_q);
		end
		if (height_q < bmnt_pkg::CfgW'(bmnt_pkg::MinDim)) begin
			cfg.height = bmnt_pkg::HgtW'(bmnt_pkg::MinDim);
		end else if (height_q > bmnt_pkg::HgtW'(bmnt_pkg::MaxHeight)) begin
			cfg.height = bmnt_pkg::HgtW'(bmnt_pkg::MaxHeight);
		end else begin
			cfg.height = height_q;
		end
		cfg.limit = limit_q;
	end

endmodule

// ===== hdl/bmnt_window.sv =====
// line stores, fill tracking, 3x3 window registers and window sum
module bmnt_window #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic                          adv,
	input  logic [$clog2(MAX_WIDTH)-1:0]  addr_s1,
	input  logic [bmnt_pkg::PixW-1:0]     pix_s1,
	output logic [bmnt_pkg::SumW-1:0]     sum
);

	localparam int FW = $clog2(MAX_WIDTH + 1);

	logic [bmnt_pkg::PixW-1:0] a_rd;
	logic [bmnt_pkg::PixW-1:0] b_rd;
	logic [bmnt_pkg::PixW-1:0] mid;
	logic [bmnt_pkg::PixW-1:0] top;
	logic [bmnt_pkg::PixW-1:0] win_q [6];
	logic [FW-1:0]             fill_q;
	logic                      hit;

	// line one above
	bmnt_ram #(.WIDTH(bmnt_pkg::PixW), .DEPTH(MAX_WIDTH)) u_line_a (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (addr_s1),
		.wr_data (pix_s1),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (a_rd)
	);

	// line two above
	bmnt_ram #(.WIDTH(bmnt_pkg::PixW), .DEPTH(MAX_WIDTH)) u_line_b (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (addr_s1),
		.wr_data (mid),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (b_rd)
	);

	// columns are written in order, so entries below the fill count are written
	assign hit = FW'(addr_s1) < fill_q;
	assign mid = hit ? a_rd : '0;
	assign top = hit ? b_rd : '0;

	// fill count and window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			if (FW'(addr_s1) == fill_q) begin
				fill_q <= fill_q + 1'b1;
			end
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top;
			win_q[1] <= mid;
			win_q[2] <= pix_s1;
		end
	end

	// nine pixel sum
	assign sum = (bmnt_pkg::SumW'(top) + bmnt_pkg::SumW'(mid) + bmnt_pkg::SumW'(pix_s1))
		+ (bmnt_pkg::SumW'(win_q[0]) + bmnt_pkg::SumW'(win_q[1]) + bmnt_pkg::SumW'(win_q[2]))
		+ (bmnt_pkg::SumW'(win_q[3]) + bmnt_pkg::SumW'(win_q[4]) + bmnt_pkg::SumW'(win_q[5]));

	// fill count never passes the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MAX_WIDTH))
		else $error("fill count beyond line store depth");

	// writes never skip past the filled region
	a_write_contig: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> FW'(addr_s1) <= fill_q)
		else $error("line store write beyond fill count");

	// a read never hits the column being written in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && adv) |-> rd_addr != addr_s1)
		else $error("line store read and write at same column");

endmodule

// ===== hdl/box_mean_negate_threshold_unit.sv =====
// top level of the 3x3 box mean, negate and threshold unit
//
// Pixels enter on in_valid/in_ready in raster order, one transaction per
// pixel, for a frame of image_width by image_height. One result leaves on
// out_valid/out_ready for every 3x3 window lying fully inside the frame;
// border pixels give no result. frame_last marks the final result of a frame.
// Registers are written on cfg_valid/cfg_ready (index 0 width, 1 height,
// 2 threshold); cfg_ready is always high, writes to index 3 are dropped.
// An accepted pixel is loaded into the read stage, then its result into the
// result register, which drives out_valid. The unit takes one pixel per
// cycle while the receiver keeps up; the line stores take one read and one
// write per cycle on separate columns.
// When the receiver stalls the result register holds, a producing pixel behind
// it waits in the read stage, and in_ready drops until the result is taken.
// Reset restores the register defaults, clears the position counters and
// the window, and marks the line stores empty through a fill count, so
// they read as zero until written; there is no clearing pass.
module box_mean_negate_threshold_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bmnt_pkg::PixW-1:0]  in_pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bmnt_pkg::PixW-1:0]  out_pixel,
	output logic                       frame_last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [bmnt_pkg::CfgW-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	bmnt_pkg::cfg_t              cfg;
	logic [AW-1:0]               col_q;
	logic [bmnt_pkg::RowW-1:0]   row_q;
	logic                        accept;
	logic                        last_col;
	logic                        last_row;
	logic                        prod;
	logic                        v_s1;
	logic                        prod_s1;
	logic                        last_s1;
	logic [AW-1:0]               addr_s1;
	logic [bmnt_pkg::PixW-1:0]   pix_s1;
	logic                        s1_go;
	logic                        out_load;
	logic                        v_s2;
	logic [bmnt_pkg::PixW-1:0]   pix_s2;
	logic                        last_s2;
	logic [bmnt_pkg::SumW-1:0]   sum;

	assign cfg_ready = 1'b1;

	bmnt_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// position decode for the incoming pixel
	assign accept   = in_valid && in_ready;
	assign last_col = (bmnt_pkg::DimW'(col_q) + bmnt_pkg::DimW'(1)) >= cfg.width;
	assign last_row = (bmnt_pkg::HgtW'(row_q) + bmnt_pkg::HgtW'(1)) >= cfg.height;
	assign prod     = (col_q >= AW'(2)) && (row_q >= bmnt_pkg::RowW'(2));

	// stage handshake
	assign s1_go    = v_s1 && (!prod_s1 || !v_s2 || out_ready);
	assign in_ready = !v_s1 || s1_go;
	assign out_load = s1_go && prod_s1;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			prod_s1 <= 1'b0;
		end else if (accept) begin
			v_s1    <= 1'b1;
			prod_s1 <= prod;
		end else if (s1_go) begin
			v_s1    <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= in_pixel;
			addr_s1 <= col_q;
			last_s1 <= last_col && last_row;
		end
	end

	bmnt_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_q),
		.adv     (s1_go),
		.addr_s1 (addr_s1),
		.pix_s1  (pix_s1),
		.sum     (sum)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_load) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	// threshold on the sum: negated mean below threshold gives black
	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_s2  <= (sum >= cfg.limit) ? bmnt_pkg::PixBlack : bmnt_pkg::PixWhite;
			last_s2 <= last_s1;
		end
	end

	assign out_valid  = v_s2;
	assign out_pixel  = pix_s2;
	assign frame_last = last_s2;

	// column counter stays inside the line store
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < MAX_WIDTH)
		else $error("column counter beyond line store depth");

	// a producing pixel leaving the read stage lands in the result register
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
		else $error("result lost between stages");

	// results are strictly binary
	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_pixel == bmnt_pkg::PixBlack || out_pixel == bmnt_pkg::PixWhite))
		else $error("result pixel not binary");

endmodule

// ===== bench/bmnt_result_checker.sv =====
// result checker for the box mean threshold unit: window predictor and in-order compare
module bmnt_result_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [bmnt_pkg::PixW-1:0] in_pixel,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [bmnt_pkg::PixW-1:0] out_pixel,
	input  logic                      frame_last,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [bmnt_pkg::CfgW-1:0] cfg_data,
	output int                        mismatches,
	output int                        waiting,
	output int                        checked
);

	typedef struct packed {
		logic [bmnt_pkg::PixW-1:0] level;
		logic                      last;
	} bin_result_t;

	// register copies
	logic [bmnt_pkg::CfgW-1:0] width_reg;
	logic [bmnt_pkg::CfgW-1:0] height_reg;
	logic [bmnt_pkg::ThrW-1:0] thr_reg;

	// line stores, previous two window columns and raster position
	logic [bmnt_pkg::PixW-1:0] line_above [MAX_WIDTH];
	logic [bmnt_pkg::PixW-1:0] line_two_above [MAX_WIDTH];
	logic [bmnt_pkg::PixW-1:0] prev_cols [6];
	int                        col_pos;
	int                        row_pos;

	bin_result_t     predicted_bins [$];
	int              n_mismatch = 0;
	int              n_checked = 0;
	int              n_waiting = 0;

	assign mismatches = n_mismatch;
	assign waiting    = n_waiting;
	assign checked    = n_checked;

	// clamp a frame dimension to what the datapath supports
	function automatic int eff_dim(input int v, input int hi);
		if (v < bmnt_pkg::MinDim) return bmnt_pkg::MinDim;
		if (v > hi) return hi;
		return v;
	endfunction

	// shift one pixel into the window, predict the result of a full interior window
	task automatic slide_window(input logic [bmnt_pkg::PixW-1:0] px, output bit produced,
		output bin_result_t res);
		int                        w;
		int                        h;
		int                        idx;
		int                        total;
		int                        neg;
		bit                        end_col;
		bit                        end_row;
		logic [bmnt_pkg::PixW-1:0] top;
		logic [bmnt_pkg::PixW-1:0] mid;
		w = eff_dim(int'(width_reg), MAX_WIDTH);
		h = eff_dim(int'(height_reg), bmnt_pkg::MaxHeight);
		idx = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
		top = line_two_above[idx];
		mid = line_above[idx];
		end_col = (col_pos + 1 >= w);
		end_row = (row_pos + 1 >= h);
		produced = (row_pos >= 2) && (col_pos >= 2);
		res = '0;
		if (produced) begin
			total = int'(top) + int'(mid) + int'(px);
			for (int k = 0; k < 6; k++) total += int'(prev_cols[k]);
			neg = 255 - total / 9;
			res.level = (neg < int'(thr_reg)) ? bmnt_pkg::PixBlack : bmnt_pkg::PixWhite;
			res.last = end_col && end_row;
		end
		line_two_above[idx] = mid;
		line_above[idx] = px;
		prev_cols[3] = prev_cols[0];
		prev_cols[4] = prev_cols[1];
		prev_cols[5] = prev_cols[2];
		prev_cols[0] = top;
		prev_cols[1] = mid;
		prev_cols[2] = px;
		// counters wrap at the line end even when already past a shrunk limit
		if (end_col) begin
			col_pos = 0;
			row_pos = end_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	// watch all three channels once per edge
	always @(posedge clk or negedge arst_n) begin
		bin_result_t got;
		bin_result_t want;
		bin_result_t res;
		bit          produced;
		if (!arst_n) begin
			width_reg = bmnt_pkg::WidthReset;
			height_reg = bmnt_pkg::HeightReset;
			thr_reg = bmnt_pkg::ThrReset;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				line_above[i] = '0;
				line_two_above[i] = '0;
			end
			for (int i = 0; i < 6; i++) prev_cols[i] = '0;
			col_pos = 0;
			row_pos = 0;
			predicted_bins.delete();
			n_waiting = 0;
		end else begin
			// result transaction, compared before this edge's pixel is predicted
			if (out_valid && out_ready) begin
				got.level = out_pixel;
				got.last = frame_last;
				if (predicted_bins.size() == 0) begin
					$error("result with none expected: out_pixel %0d frame_last %0d",
						got.level, got.last);
					n_mismatch++;
				end else begin
					want = predicted_bins.pop_front();
					n_checked++;
					if (got.level !== want.level) begin
						$error("out_pixel: expected %0d, got %0d", want.level, got.level);
						n_mismatch++;
					end
					if (got.last !== want.last) begin
						$error("frame_last: expected %0d, got %0d", want.last, got.last);
						n_mismatch++;
					end
				end
			end
			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bmnt_pkg::CFG_WIDTH:     width_reg = cfg_data;
					bmnt_pkg::CFG_HEIGHT:    height_reg = cfg_data;
					bmnt_pkg::CFG_THRESHOLD: thr_reg = cfg_data[bmnt_pkg::ThrW-1:0];
					default:                 ;
				endcase
			end
			// pixel transaction
			if (in_valid && in_ready) begin
				slide_window(in_pixel, produced, res);
				if (produced) predicted_bins.push_back(res);
			end
			n_waiting = predicted_bins.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// testbench top for the box mean threshold unit: clock, reset, stimulus and verdict
module tb_top;

	localparam int         MaxWidth     = 1024;
	localparam int         RandomPixels = 950;
	localparam logic [1:0] CfgUnused    = 2'd3;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [bmnt_pkg::PixW-1:0] in_pixel;
	logic                      out_valid;
	logic                      out_ready = 1'b1;
	logic [bmnt_pkg::PixW-1:0] out_pixel;
	logic                      frame_last;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [1:0]                cfg_index;
	logic [bmnt_pkg::CfgW-1:0] cfg_data;

	int              mismatches;
	int              waiting;
	int              checked;
	bit              gaps_on = 1'b1;
	int              pixels_sent = 0;
	int              settings = 0;

	always #5 clk = ~clk;

	box_mean_negate_threshold_unit #(
		.MAX_WIDTH(MaxWidth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_pixel(in_pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_pixel(out_pixel),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bmnt_result_checker #(
		.MAX_WIDTH(MaxWidth)
	) bin_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_pixel(in_pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_pixel(out_pixel),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.waiting(waiting),
		.checked(checked)
	);

	// receiver stalls at random while gaps are enabled
	always @(negedge clk) begin
		out_ready <= !gaps_on || ($urandom_range(0, 99) >= 28);
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("[box_mean_negate_threshold_unit] ERROR");
		$finish;
	end

	function automatic int eff_dim(input int v);
		if (v < bmnt_pkg::MinDim) return bmnt_pkg::MinDim;
		if (v > MaxWidth) return MaxWidth;
		return v;
	endfunction

	// mostly small dimensions, now and then out of range on either side
	function automatic int pick_dim(input int small_max);
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom_range(0, 2);
		if (r == 1) return $urandom_range(MaxWidth, 2047);
		return $urandom_range(bmnt_pkg::MinDim, small_max);
	endfunction

	// noise around a base level, flat random, or pure black and white
	function automatic logic [bmnt_pkg::PixW-1:0] scene_pixel(input int mode, input int base);
		int v;
		case (mode)
			0: v = $urandom_range(0, 255);
			1: v = base + int'($urandom_range(0, 32)) - 16;
			default: v = $urandom_range(0, 1) ? 255 : 0;
		endcase
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[bmnt_pkg::PixW-1:0];
	endfunction

	// one pixel transaction, with random idle cycles ahead of it while gaps are enabled
	task automatic send_pixel(input logic [bmnt_pkg::PixW-1:0] px);
		while (gaps_on && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_pixel <= px;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic stream(input int count, input int mode, input int base);
		for (int i = 0; i < count; i++) send_pixel(scene_pixel(mode, base));
	endtask

	// one register write transaction; cfg_valid is low again before the task returns
	task automatic write_reg(input logic [1:0] idx, input logic [bmnt_pkg::CfgW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// hold pixels until every predicted result is out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (waiting != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(input int w, input int h, input int thr);
		settle();
		write_reg(bmnt_pkg::CFG_WIDTH, w[bmnt_pkg::CfgW-1:0]);
		write_reg(bmnt_pkg::CFG_HEIGHT, h[bmnt_pkg::CfgW-1:0]);
		write_reg(bmnt_pkg::CFG_THRESHOLD, thr[bmnt_pkg::CfgW-1:0]);
		settings++;
	endtask

	// stimulus
	initial begin
		int random_pixels;
		int mode;
		int base;
		int w;
		int h;
		int thr;
		int r;
		int frame_size;
		int count;
		in_valid = 1'b0;
		in_pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = bmnt_pkg::CFG_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// under-range sizes clamp to 3x3; threshold above 255 forces black
		configure(2, 0, 256);
		stream(9, 2, 255);
		for (int i = 0; i < 9; i++) send_pixel(bmnt_pkg::PixWhite);
		// threshold zero forces white
		configure(3, 3, 0);
		for (int i = 0; i < 9; i++) send_pixel(bmnt_pkg::PixBlack);

		// long run with no idling at all, height written above range
		gaps_on = 1'b0;
		configure(12, 2047, 128);
		stream(200, 0, 0);
		gaps_on = 1'b1;

		// partial frame at threshold one; the index with no register is dropped
		configure(3, 3, 1);
		write_reg(CfgUnused, 11'h7FF);
		for (int i = 0; i < 7; i++) send_pixel(i[0] ? bmnt_pkg::PixWhite : bmnt_pkg::PixBlack);

		// random phases, mostly whole small frames, some cut short mid frame
		random_pixels = 0;
		while (random_pixels < RandomPixels) begin
			mode = $urandom_range(0, 2);
			base = $urandom_range(0, 255);
			w = pick_dim(12);
			h = pick_dim(8);
			r = $urandom_range(0, 9);
			if (r == 0) thr = 0;
			else if (r == 1) thr = 256;
			else if (r == 2) thr = 255;
			else if (mode == 1) thr = 255 - base + int'($urandom_range(0, 12)) - 6;
			else thr = $urandom_range(100, 156);
			if (thr < 0) thr = 0;
			if (thr > 256) thr = 256;
			frame_size = eff_dim(w) * eff_dim(h);
			if (frame_size > 200) count = $urandom_range(40, 300);
			else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, 2 * frame_size);
			else count = $urandom_range(1, 3) * frame_size;
			if (count > RandomPixels - random_pixels) count = RandomPixels - random_pixels;
			gaps_on = ($urandom_range(0, 6) != 0);
			configure(w, h, thr);
			stream(count, mode, base);
			random_pixels += count;
		end

		gaps_on = 1'b1;
		settle();
		repeat (4) @(negedge clk);

		$display("covered %0d pixels over %0d register settings, %0d results checked",
			pixels_sent, settings, checked);
		$display("sizes clamped below and above range, a long run with no idling, "
			, "thresholds 0 to 256, frames cut mid line");
		if (mismatches == 0 && waiting == 0) begin
			$display("[box_mean_negate_threshold_unit] OK");
		end else begin
			$display("[box_mean_negate_threshold_unit] ERROR");
		end
		$finish;
	end

endmodule
